>>> design/crp_pkg.sv
// ----------------------------------------------------------------------------
// crp_pkg
// shared types and constants of the control request processor: sizes,
// request header layout, opcodes, result codes and sequencer encodings
// ----------------------------------------------------------------------------
package crp_pkg;

	// buffer and echo sizes
	localparam int MAX_REQUEST = 32;
	localparam int MAX_ECHO    = 16;
	localparam int ADDR_W      = $clog2(MAX_REQUEST);
	localparam int CNT_W       = $clog2(MAX_REQUEST + 1);
	localparam int BASE_LEN    = 10;
	localparam int IDX_W       = $clog2(BASE_LEN + MAX_ECHO + 1);
	localparam int HDR_LEN     = 8;
	localparam int CMP_W       = 16;

	// request header layout, byte positions
	localparam int HP_VERSION = 0;
	localparam int HP_OPCODE  = 1;
	localparam int HP_ID      = 2;
	localparam int HP_LEN     = 4;
	localparam int HP_RSV     = 6;
	localparam int HP_ARG     = 8;
	localparam int HP_RATE    = 10;
	localparam int HP_TAIL    = 14;

	// response payload layout, byte positions
	localparam int RP_ID_LO  = 0;
	localparam int RP_ID_HI  = 1;
	localparam int RP_OPCODE = 2;
	localparam int RP_RESULT = 3;
	localparam int RP_MASK   = 4;
	localparam int RP_RATE   = 6;

	localparam logic [7:0] VERSION_ONE = 8'h01;

	// opcodes
	localparam logic [7:0] OP_SET_STREAMS = 8'h01;
	localparam logic [7:0] OP_SET_SUBJECT = 8'h02;
	localparam logic [7:0] OP_SNAPSHOT    = 8'h03;
	localparam logic [7:0] OP_PING        = 8'h04;

	// argument limits
	localparam logic [7:0]  RATE_MIN    = 8'd1;
	localparam logic [7:0]  RATE_MAX    = 8'd10;
	localparam logic [15:0] SUBJECT_ALL = 16'hFFFF;
	localparam int          STREAMS_LEN = 8;
	localparam int          ARG16_LEN   = 2;

	// result codes
	localparam logic [1:0] RES_OK     = 2'd0;
	localparam logic [1:0] RES_UNSUP  = 2'd1;
	localparam logic [1:0] RES_INVAL  = 2'd2;
	localparam logic [1:0] RES_BUSY   = 2'd3;

	// reject codes
	localparam logic REJ_HEADER   = 1'b0;
	localparam logic REJ_OVERFLOW = 1'b1;

	// reset values of kept settings
	localparam logic [1:0] MASK_RESET = 2'd3;
	localparam logic [3:0] RATE_RESET = 4'd2;

	typedef enum logic [1:0] {
		ST_RECV,
		ST_CHECK,
		ST_EMIT
	} crp_state_t;

	typedef enum logic [3:0] {
		CK_SHORT,
		CK_VER,
		CK_RSV,
		CK_LEN,
		CK_PLEN,
		CK_TAIL,
		CK_RATE_LO,
		CK_RATE_HI,
		CK_MASK
	} chk_step_t;

	typedef enum logic {
		CMP_EQ,
		CMP_LT
	} cmp_op_t;

	typedef struct packed {
		cmp_op_t            op;
		logic [CMP_W-1:0]   a;
		logic [CMP_W-1:0]   b;
	} cmp_req_t;

endpackage

>>> design/control_request_processor_unit.sv
// ----------------------------------------------------------------------------
// control_request_processor_unit
// buffers a control request, checks its header, runs its opcode and
// streams out a reject word or a response payload
// ----------------------------------------------------------------------------
// Request bytes are taken one word per cycle while the unit is receiving.
// After the word marked last the input stalls: an overflowed request goes
// straight to a single reject word; otherwise a sequencer walks the header
// and opcode checks through one shared compare unit, one check per cycle.
// The response then leaves through an output register: the ten fixed
// payload bytes one per cycle while the output is not stalled, echo bytes
// only once the registered read of each one from the request memory has
// completed. The input opens again once the final word sits in the output
// register, so the next request can arrive while that word waits to be
// taken. The kept stream mask and vitals rate are updated before the
// payload that reports them.
// ----------------------------------------------------------------------------
module control_request_processor_unit
	import crp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// request side
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] req_byte,
	input  logic       req_last,
	input  logic       resp_busy,
	// result side
	output logic       out_valid,
	input  logic       out_stall,
	output logic       out_kind,
	output logic [7:0] resp_byte,
	output logic       reject_code,
	output logic       snap_status,
	output logic       snap_vitals,
	output logic       out_last
);

	// request memory, echo bytes are read back from here
	logic [7:0] mem [MAX_REQUEST];
	logic [7:0] mem_rd_q;
	logic [ADDR_W-1:0] rd_addr;

	// receive bookkeeping
	logic [CNT_W-1:0] byte_count_q;
	logic             overflowed_q;
	logic             in_fire;
	logic             store_ok;
	logic             ovf_now;

	// header and argument fields captured as they stream in
	logic [7:0]  ver_q;
	logic [7:0]  opcode_q;
	logic [15:0] id_q;
	logic [15:0] hdrlen_q;
	logic [15:0] rsv_q;
	logic [15:0] arg_q;
	logic [7:0]  rate_arg_q;
	logic [15:0] tail_q;

	// per-request state
	logic [CNT_W-1:0] len_q;
	logic             busy_q;
	logic             rej_q;
	logic             rej_code_q;
	logic [1:0]       result_q;
	logic             ss_q;
	logic             sv_q;
	logic [IDX_W-1:0] last_idx_q;
	logic [IDX_W-1:0] idx_q;
	logic             rd_ok_q;

	// kept settings
	logic [1:0] mask_q;
	logic [3:0] rate_q;

	// sequencer
	crp_state_t state_q, state_d;
	chk_step_t  step_q, step_d;
	cmp_req_t   cmp_req;
	logic       cmp_hit;
	logic       go_reject;
	logic       res_set;
	logic [1:0] res_val;
	logic       upd_streams;
	logic       snap_set;
	logic       echo_set;

	logic [CNT_W-1:0]  plen;
	logic [CMP_W-1:0]  plen_w;

	// output register
	logic       out_valid_q;
	logic       out_kind_q;
	logic [7:0] resp_byte_q;
	logic       reject_code_q;
	logic       snap_status_q;
	logic       snap_vitals_q;
	logic       out_last_q;
	logic       load;
	logic       item_last;
	logic [7:0] item_byte;

	assign in_stall = (state_q != ST_RECV);
	assign in_fire  = in_valid && !in_stall;
	assign store_ok = (byte_count_q < CNT_W'(MAX_REQUEST));
	assign ovf_now  = overflowed_q || !store_ok;

	assign plen   = len_q - CNT_W'(HDR_LEN);
	assign plen_w = CMP_W'(plen);

	// echo byte k of the payload sits at request byte 8 + k
	assign rd_addr = ADDR_W'(idx_q - IDX_W'(BASE_LEN - HP_ARG));

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (in_fire && store_ok) begin
			mem[byte_count_q[ADDR_W-1:0]] <= req_byte;
		end
		mem_rd_q <= mem[rd_addr];
	end

	// capture of fixed-position header and argument bytes
	always_ff @(posedge clk) begin
		if (in_fire && store_ok) begin
			if (byte_count_q == CNT_W'(HP_VERSION))  ver_q           <= req_byte;
			if (byte_count_q == CNT_W'(HP_OPCODE))   opcode_q        <= req_byte;
			if (byte_count_q == CNT_W'(HP_ID))       id_q[7:0]       <= req_byte;
			if (byte_count_q == CNT_W'(HP_ID + 1))   id_q[15:8]      <= req_byte;
			if (byte_count_q == CNT_W'(HP_LEN))      hdrlen_q[7:0]   <= req_byte;
			if (byte_count_q == CNT_W'(HP_LEN + 1))  hdrlen_q[15:8]  <= req_byte;
			if (byte_count_q == CNT_W'(HP_RSV))      rsv_q[7:0]      <= req_byte;
			if (byte_count_q == CNT_W'(HP_RSV + 1))  rsv_q[15:8]     <= req_byte;
			if (byte_count_q == CNT_W'(HP_ARG))      arg_q[7:0]      <= req_byte;
			if (byte_count_q == CNT_W'(HP_ARG + 1))  arg_q[15:8]     <= req_byte;
			if (byte_count_q == CNT_W'(HP_RATE))     rate_arg_q      <= req_byte;
			if (byte_count_q == CNT_W'(HP_TAIL))     tail_q[7:0]     <= req_byte;
			if (byte_count_q == CNT_W'(HP_TAIL + 1)) tail_q[15:8]    <= req_byte;
		end
	end

	// shared compare unit
	crp_cmp u_cmp (
		.req (cmp_req),
		.hit (cmp_hit)
	);

	// next state and check sequencing
	always_comb begin
		state_d     = state_q;
		step_d      = step_q;
		go_reject   = 1'b0;
		res_set     = 1'b0;
		res_val     = RES_OK;
		upd_streams = 1'b0;
		snap_set    = 1'b0;
		echo_set    = 1'b0;
		cmp_req     = '{op: CMP_EQ, a: '0, b: '0};
		unique case (state_q)
			ST_RECV: begin
				if (in_fire && req_last) begin
					state_d = ovf_now ? ST_EMIT : ST_CHECK;
					step_d  = CK_SHORT;
				end
			end
			ST_CHECK: begin
				unique case (step_q)
					// header checks, any miss rejects the request
					CK_SHORT: begin
						cmp_req = '{op: CMP_LT, a: CMP_W'(len_q), b: CMP_W'(HDR_LEN)};
						if (cmp_hit) begin
							go_reject = 1'b1;
							state_d   = ST_EMIT;
						end else begin
							step_d = CK_VER;
						end
					end
					CK_VER: begin
						cmp_req = '{op: CMP_EQ, a: CMP_W'(ver_q), b: CMP_W'(VERSION_ONE)};
						if (!cmp_hit) begin
							go_reject = 1'b1;
							state_d   = ST_EMIT;
						end else begin
							step_d = CK_RSV;
						end
					end
					CK_RSV: begin
						cmp_req = '{op: CMP_EQ, a: rsv_q, b: '0};
						if (!cmp_hit) begin
							go_reject = 1'b1;
							state_d   = ST_EMIT;
						end else begin
							step_d = CK_LEN;
						end
					end
					CK_LEN: begin
						cmp_req = '{op: CMP_EQ, a: hdrlen_q, b: plen_w};
						if (!cmp_hit) begin
							go_reject = 1'b1;
							state_d   = ST_EMIT;
						end else if (busy_q) begin
							res_set = 1'b1;
							res_val = RES_BUSY;
							state_d = ST_EMIT;
						end else begin
							unique case (opcode_q)
								OP_SET_STREAMS, OP_SET_SUBJECT, OP_SNAPSHOT, OP_PING: begin
									step_d = CK_PLEN;
								end
								default: begin
									res_set = 1'b1;
									res_val = RES_UNSUP;
									state_d = ST_EMIT;
								end
							endcase
						end
					end
					// payload length per opcode
					CK_PLEN: begin
						if (opcode_q == OP_PING) begin
							cmp_req = '{op: CMP_LT, a: CMP_W'(MAX_ECHO), b: plen_w};
							if (cmp_hit) begin
								res_set = 1'b1;
								res_val = RES_INVAL;
							end else begin
								echo_set = 1'b1;
							end
							state_d = ST_EMIT;
						end else if (opcode_q == OP_SET_STREAMS) begin
							cmp_req = '{op: CMP_EQ, a: plen_w, b: CMP_W'(STREAMS_LEN)};
							if (!cmp_hit) begin
								res_set = 1'b1;
								res_val = RES_INVAL;
								state_d = ST_EMIT;
							end else begin
								step_d = CK_TAIL;
							end
						end else begin
							cmp_req = '{op: CMP_EQ, a: plen_w, b: CMP_W'(ARG16_LEN)};
							if (!cmp_hit) begin
								res_set = 1'b1;
								res_val = RES_INVAL;
								state_d = ST_EMIT;
							end else begin
								step_d = CK_MASK;
							end
						end
					end
					// set streams argument checks
					CK_TAIL: begin
						cmp_req = '{op: CMP_EQ, a: tail_q, b: '0};
						if (!cmp_hit) begin
							res_set = 1'b1;
							res_val = RES_INVAL;
							state_d = ST_EMIT;
						end else begin
							step_d = CK_RATE_LO;
						end
					end
					CK_RATE_LO: begin
						cmp_req = '{op: CMP_LT, a: CMP_W'(rate_arg_q), b: CMP_W'(RATE_MIN)};
						if (cmp_hit) begin
							res_set = 1'b1;
							res_val = RES_INVAL;
							state_d = ST_EMIT;
						end else begin
							step_d = CK_RATE_HI;
						end
					end
					CK_RATE_HI: begin
						cmp_req = '{op: CMP_LT, a: CMP_W'(RATE_MAX), b: CMP_W'(rate_arg_q)};
						if (cmp_hit) begin
							res_set = 1'b1;
							res_val = RES_INVAL;
							state_d = ST_EMIT;
						end else begin
							upd_streams = 1'b1;
							step_d      = CK_MASK;
						end
					end
					// argument word: subject must be all ones, masks only two bits
					CK_MASK: begin
						if (opcode_q == OP_SET_SUBJECT) begin
							cmp_req = '{op: CMP_EQ, a: arg_q, b: SUBJECT_ALL};
						end else begin
							cmp_req = '{op: CMP_EQ, a: {arg_q[15:2], 2'b00}, b: '0};
						end
						if (!cmp_hit) begin
							res_set = 1'b1;
							res_val = RES_UNSUP;
						end
						snap_set = (opcode_q == OP_SNAPSHOT);
						state_d  = ST_EMIT;
					end
					default: begin
						go_reject = 1'b1;
						state_d   = ST_EMIT;
					end
				endcase
			end
			ST_EMIT: begin
				if (load && item_last) begin
					state_d = ST_RECV;
				end
			end
			default: begin
				state_d = ST_RECV;
			end
		endcase
	end

	// state and step registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RECV;
			step_q  <= CK_SHORT;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	// receive counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			overflowed_q <= 1'b0;
		end else if (in_fire) begin
			if (req_last) begin
				byte_count_q <= '0;
				overflowed_q <= 1'b0;
			end else if (store_ok) begin
				byte_count_q <= byte_count_q + CNT_W'(1);
			end else begin
				overflowed_q <= 1'b1;
			end
		end
	end

	// per-request decision registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			busy_q     <= 1'b0;
			rej_q      <= 1'b0;
			rej_code_q <= REJ_HEADER;
			result_q   <= RES_OK;
			ss_q       <= 1'b0;
			sv_q       <= 1'b0;
			last_idx_q <= IDX_W'(BASE_LEN - 1);
		end else if (in_fire && req_last) begin
			len_q      <= store_ok ? byte_count_q + CNT_W'(1) : byte_count_q;
			busy_q     <= resp_busy;
			rej_q      <= ovf_now;
			rej_code_q <= ovf_now ? REJ_OVERFLOW : REJ_HEADER;
			result_q   <= RES_OK;
			ss_q       <= 1'b0;
			sv_q       <= 1'b0;
			last_idx_q <= IDX_W'(BASE_LEN - 1);
		end else if (state_q == ST_CHECK) begin
			if (go_reject) begin
				rej_q      <= 1'b1;
				rej_code_q <= REJ_HEADER;
			end
			if (res_set) begin
				result_q <= res_val;
			end
			if (snap_set) begin
				ss_q <= arg_q[0];
				sv_q <= arg_q[1];
			end
			if (echo_set) begin
				last_idx_q <= IDX_W'(BASE_LEN - 1) + IDX_W'(plen);
			end
		end
	end

	// kept stream mask and vitals rate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= MASK_RESET;
			rate_q <= RATE_RESET;
		end else if (state_q == ST_CHECK && upd_streams) begin
			mask_q <= arg_q[1:0];
			rate_q <= rate_arg_q[3:0];
		end
	end

	// response byte selection
	always_comb begin
		unique case (idx_q)
			IDX_W'(RP_ID_LO):  item_byte = id_q[7:0];
			IDX_W'(RP_ID_HI):  item_byte = id_q[15:8];
			IDX_W'(RP_OPCODE): item_byte = opcode_q;
			IDX_W'(RP_RESULT): item_byte = {6'b0, result_q};
			IDX_W'(RP_MASK):   item_byte = {6'b0, mask_q};
			IDX_W'(RP_RATE):   item_byte = {4'b0, rate_q};
			default: begin
				item_byte = (idx_q < IDX_W'(BASE_LEN)) ? 8'h00 : mem_rd_q;
			end
		endcase
	end

	// echo bytes wait for the registered memory read of the current index
	assign item_last = rej_q || (idx_q == last_idx_q);
	assign load      = (state_q == ST_EMIT) && (!out_valid_q || !out_stall) &&
	                   (rej_q || idx_q < IDX_W'(BASE_LEN) || rd_ok_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			rd_ok_q <= !load;
			if (state_q != ST_EMIT) begin
				idx_q <= '0;
			end else if (load) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_kind_q    <= rej_q;
			resp_byte_q   <= rej_q ? 8'h00 : item_byte;
			reject_code_q <= rej_q ? rej_code_q : 1'b0;
			snap_status_q <= !rej_q && item_last && ss_q;
			snap_vitals_q <= !rej_q && item_last && sv_q;
			out_last_q    <= item_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_kind    = out_kind_q;
	assign resp_byte   = resp_byte_q;
	assign reject_code = reject_code_q;
	assign snap_status = snap_status_q;
	assign snap_vitals = snap_vitals_q;
	assign out_last    = out_last_q;

	// a reject is always a single word
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind_q |-> out_last_q)
		else $error("reject word not marked last");

	// snapshot flags only ride on the final payload word
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (snap_status_q || snap_vitals_q) |-> out_last_q && !out_kind_q)
		else $error("snapshot flag on a non-final or reject word");

	// kept vitals rate stays within its legal range
	assert property (@(posedge clk) disable iff (!arst_n)
		rate_q >= RATE_MIN[3:0] && rate_q <= RATE_MAX[3:0])
		else $error("vitals rate out of range");

	// once the final word is loaded the unit is receiving again
	assert property (@(posedge clk) disable iff (!arst_n)
		load && item_last |=> state_q == ST_RECV)
		else $error("sequencer did not return to receive");

endmodule

>>> design/crp_cmp.sv
// ----------------------------------------------------------------------------
// crp_cmp
// shared 16-bit compare unit: equality or unsigned less-than of two operands
// ----------------------------------------------------------------------------
module crp_cmp
	import crp_pkg::*;
(
	input  cmp_req_t req,
	output logic     hit
);

	always_comb begin
		unique case (req.op)
			CMP_EQ: hit = (req.a == req.b);
			CMP_LT: hit = (req.a < req.b);
			default: hit = 1'b0;
		endcase
	end

endmodule
